>>> src/tqc_pkg.sv
`timescale 1ns / 1ps
// Shared types, constants and helpers for the ticket queue with cancel.
// Used by every module of the block; depends on nothing.
package tqc_pkg;

  localparam int DEPTH    = 8;
  localparam int TICKET_W = 16;
  localparam int POS_W    = 4;
  localparam int POS_MAX  = (1 << POS_W) - 1;

  localparam logic [TICKET_W-1:0] TICKET_MAX = {TICKET_W{1'b1}};
  localparam logic [TICKET_W-1:0] TICKET_ONE = {{(TICKET_W-1){1'b0}}, 1'b1};

  typedef enum logic [1:0] {
    OP_TAKE   = 2'd0,
    OP_SERVE  = 2'd1,
    OP_CANCEL = 2'd2,
    OP_CHECK  = 2'd3
  } op_t;

  // request broadcast to every cell
  typedef struct packed {
    logic                valid;
    op_t                 op;
    logic [TICKET_W-1:0] key;
    logic [TICKET_W-1:0] ticket;
  } req_t;

  // link between neighboring cells
  typedef struct packed {
    logic full;
    logic found;
  } link_t;

  // status of the whole row, seen before the update
  typedef struct packed {
    logic             head_full;
    logic             full;
    logic             found;
    logic [POS_W-1:0] position;
  } stat_t;

  function automatic logic [TICKET_W-1:0] nonzero_ticket(input logic [TICKET_W-1:0] v);
    nonzero_ticket = (v == '0) ? TICKET_ONE : v;
  endfunction

  function automatic logic [POS_W-1:0] pos_of(input int idx);
    if (idx + 1 > POS_MAX) begin
      pos_of = POS_W'(POS_MAX);
    end else begin
      pos_of = POS_W'(idx + 1);
    end
  endfunction

endpackage

>>> src/ticket_queue_with_cancel_unit.sv
`timescale 1ns / 1ps
// Ticket queue with cancel: compacted FIFO of nonzero tickets in a row of cells.
// Depends on tqc_pkg and tqc_chain.
//
// Usage:
//   Input channel in_valid/in_stall carries a request: in_opcode (take, serve,
//   cancel, check) and in_ticket_key. The request is accepted on a clock edge
//   with in_valid high and in_stall low.
//   Result channel out_valid/out_stall carries out_ok, out_position and
//   out_issued_ticket, one result per request, in request order.
//   cfg_valid/cfg_ready writes cfg_first_ticket (zero is taken as 1) and
//   reloads the ticket counter; cfg_ready is always high.
// Timing:
//   Each request updates every slot in the cycle it is accepted; its result
//   is registered into the output stage. One request per cycle while in_stall
//   is low, as the compare and neighbor shift along the cell row are combinational.
//   A two-entry output stage keeps accepting while one result waits; in_stall
//   is high while both entries hold results and clears the cycle after
//   out_stall drops.
// Reset:
//   rst_n (synchronous, active low) empties all slots, sets the counter to 1
//   and drops any pending results.
module ticket_queue_with_cancel_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [1:0]                    in_opcode,
  input  logic [tqc_pkg::TICKET_W-1:0]  in_ticket_key,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          out_ok,
  output logic [tqc_pkg::POS_W-1:0]     out_position,
  output logic [tqc_pkg::TICKET_W-1:0]  out_issued_ticket,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [tqc_pkg::TICKET_W-1:0]  cfg_first_ticket
);

  tqc_pkg::req_t                req;
  tqc_pkg::stat_t               stat;
  tqc_pkg::op_t                 op;
  logic                         accept;
  logic                         take_ok;

  logic [tqc_pkg::TICKET_W-1:0] next_ticket_r;
  logic [tqc_pkg::TICKET_W-1:0] next_ticket_nxt;

  logic                         res_ok;
  logic [tqc_pkg::POS_W-1:0]    res_pos;
  logic [tqc_pkg::TICKET_W-1:0] res_issued;

  logic                         out_vld_r;
  logic                         out_ok_r;
  logic [tqc_pkg::POS_W-1:0]    out_pos_r;
  logic [tqc_pkg::TICKET_W-1:0] out_iss_r;
  logic                         skid_vld_r;
  logic                         skid_ok_r;
  logic [tqc_pkg::POS_W-1:0]    skid_pos_r;
  logic [tqc_pkg::TICKET_W-1:0] skid_iss_r;

  assign op         = tqc_pkg::op_t'(in_opcode);
  assign in_stall   = skid_vld_r;
  assign accept     = in_valid && !skid_vld_r;
  assign cfg_ready  = 1'b1;

  assign req.valid  = accept;
  assign req.op     = op;
  assign req.key    = in_ticket_key;
  assign req.ticket = next_ticket_r;

  tqc_chain u_chain (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (req),
    .stat  (stat)
  );

  assign take_ok = !stat.full;

  // result of the current request, from the row before it updates
  always_comb begin
    res_ok     = 1'b0;
    res_pos    = '0;
    res_issued = '0;
    case (op)
      tqc_pkg::OP_TAKE: begin
        res_ok     = take_ok;
        res_issued = take_ok ? next_ticket_r : '0;
      end
      tqc_pkg::OP_SERVE: begin
        res_ok = stat.head_full;
      end
      tqc_pkg::OP_CANCEL: begin
        res_ok = stat.found;
      end
      tqc_pkg::OP_CHECK: begin
        res_ok  = stat.found;
        res_pos = stat.position;
      end
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  always_comb begin
    next_ticket_nxt = next_ticket_r;
    if (cfg_valid) begin
      next_ticket_nxt = tqc_pkg::nonzero_ticket(cfg_first_ticket);
    end else if (accept && op == tqc_pkg::OP_TAKE && take_ok) begin
      next_ticket_nxt = (next_ticket_r == tqc_pkg::TICKET_MAX) ?
                        tqc_pkg::TICKET_ONE : next_ticket_r + tqc_pkg::TICKET_ONE;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      next_ticket_r <= tqc_pkg::TICKET_ONE;
    end else begin
      next_ticket_r <= next_ticket_nxt;
    end
  end

  // two-entry output stage: main register plus skid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r  <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (!out_vld_r || !out_stall) begin
      if (skid_vld_r) begin
        out_vld_r  <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        out_vld_r <= accept;
      end
    end else if (accept) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!out_vld_r || !out_stall) begin
      if (skid_vld_r) begin
        out_ok_r  <= skid_ok_r;
        out_pos_r <= skid_pos_r;
        out_iss_r <= skid_iss_r;
      end else if (accept) begin
        out_ok_r  <= res_ok;
        out_pos_r <= res_pos;
        out_iss_r <= res_issued;
      end
    end else if (accept) begin
      skid_ok_r  <= res_ok;
      skid_pos_r <= res_pos;
      skid_iss_r <= res_issued;
    end
  end

  assign out_valid         = out_vld_r;
  assign out_ok            = out_ok_r;
  assign out_position      = out_pos_r;
  assign out_issued_ticket = out_iss_r;

endmodule

>>> src/tqc_cell.sv
`timescale 1ns / 1ps
// One slot of the queue: holds a ticket, matches the key, takes its neighbor.
// Depends on tqc_pkg.
module tqc_cell (
  input  logic                          clk,
  input  logic                          rst_n,
  input  tqc_pkg::req_t                 req,
  input  tqc_pkg::link_t                link_in,
  input  logic [tqc_pkg::TICKET_W-1:0]  nbr_slot,
  output tqc_pkg::link_t                link_out,
  output logic [tqc_pkg::TICKET_W-1:0]  slot,
  output logic                          hit
);

  logic [tqc_pkg::TICKET_W-1:0] slot_r;
  logic [tqc_pkg::TICKET_W-1:0] slot_nxt;
  logic                         occ;
  logic                         match;

  assign occ            = (slot_r != '0);
  assign match          = (req.key != '0) && (slot_r == req.key);
  assign hit            = match && !link_in.found;
  assign link_out.full  = occ;
  assign link_out.found = link_in.found || match;
  assign slot           = slot_r;

  always_comb begin
    slot_nxt = slot_r;
    if (req.valid) begin
      case (req.op)
        tqc_pkg::OP_TAKE: begin
          if (!occ && link_in.full) slot_nxt = req.ticket;
        end
        tqc_pkg::OP_SERVE: begin
          slot_nxt = nbr_slot;
        end
        tqc_pkg::OP_CANCEL: begin
          if (link_out.found) slot_nxt = nbr_slot;
        end
        default: begin
          slot_nxt = slot_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      slot_r <= '0;
    end else begin
      slot_r <= slot_nxt;
    end
  end

endmodule

>>> src/tqc_chain.sv
`timescale 1ns / 1ps
// Row of DEPTH slot cells with head at cell 0, plus the position encoder.
// Depends on tqc_pkg and tqc_cell.
module tqc_chain (
  input  logic           clk,
  input  logic           rst_n,
  input  tqc_pkg::req_t  req,
  output tqc_pkg::stat_t stat
);

  tqc_pkg::link_t               link [0:tqc_pkg::DEPTH];
  logic [tqc_pkg::TICKET_W-1:0] slot_w [0:tqc_pkg::DEPTH];
  logic [tqc_pkg::DEPTH-1:0]    hit;
  logic [tqc_pkg::POS_W-1:0]    pos;

  assign link[0].full                = 1'b1;
  assign link[0].found               = 1'b0;
  assign slot_w[tqc_pkg::DEPTH]      = '0;

  for (genvar i = 0; i < tqc_pkg::DEPTH; i++) begin : g_cell
    tqc_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .req      (req),
      .link_in  (link[i]),
      .nbr_slot (slot_w[i+1]),
      .link_out (link[i+1]),
      .slot     (slot_w[i]),
      .hit      (hit[i])
    );
  end

  always_comb begin
    pos = '0;
    for (int i = 0; i < tqc_pkg::DEPTH; i++) begin
      if (hit[i]) pos = pos | tqc_pkg::pos_of(i);
    end
  end

  assign stat.head_full = (slot_w[0] != '0);
  assign stat.full      = link[tqc_pkg::DEPTH].full;
  assign stat.found     = link[tqc_pkg::DEPTH].found;
  assign stat.position  = pos;

endmodule

>>> src/tqc_checker.sv
`timescale 1ns / 1ps
// Port-level checker for the ticket queue with cancel, bound to the top level.
// Depends on tqc_pkg.
module tqc_checker (
  input logic                          clk,
  input logic                          rst_n,
  input logic                          out_valid,
  input logic                          out_stall,
  input logic                          out_ok,
  input logic [tqc_pkg::POS_W-1:0]     out_position,
  input logic [tqc_pkg::TICKET_W-1:0]  out_issued_ticket
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_issued_ticket) &&
      $stable(out_position) && $stable(out_ok))
    else $error("stalled result changed");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_issue_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_issued_ticket != '0 |-> out_ok)
    else $error("ticket issued without success");

  a_pos_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_position != '0 |-> out_ok && out_issued_ticket == '0)
    else $error("position reported on a failed or take request");

endmodule

bind ticket_queue_with_cancel_unit tqc_checker u_tqc_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_stall         (out_stall),
  .out_ok            (out_ok),
  .out_position      (out_position),
  .out_issued_ticket (out_issued_ticket)
);

>>> tb/tb_ticket_queue_with_cancel_unit.sv
`timescale 1ns / 1ps
// Self-checking testbench for ticket_queue_with_cancel_unit: directed and random
// take, serve, cancel and check requests scored against an in-bench queue model.
// Depends on tqc_pkg and the RTL of the unit.
module tb_ticket_queue_with_cancel_unit;

  typedef struct packed {
    tqc_pkg::op_t                 op;
    logic [tqc_pkg::TICKET_W-1:0] key;
  } request_t;

  typedef struct packed {
    logic                         ok;
    logic [tqc_pkg::POS_W-1:0]    position;
    logic [tqc_pkg::TICKET_W-1:0] issued;
  } reply_t;

  logic                         clk              = 1'b0;
  logic                         rst_n            = 1'b0;
  logic                         in_valid         = 1'b0;
  logic                         in_stall;
  logic [1:0]                   in_opcode        = tqc_pkg::OP_TAKE;
  logic [tqc_pkg::TICKET_W-1:0] in_ticket_key    = '0;
  logic                         out_valid;
  logic                         out_stall        = 1'b0;
  logic                         out_ok;
  logic [tqc_pkg::POS_W-1:0]    out_position;
  logic [tqc_pkg::TICKET_W-1:0] out_issued_ticket;
  logic                         cfg_valid        = 1'b0;
  logic                         cfg_ready;
  logic [tqc_pkg::TICKET_W-1:0] cfg_first_ticket = '0;

  logic [tqc_pkg::TICKET_W-1:0] ticket_slots [tqc_pkg::DEPTH];
  logic [tqc_pkg::TICKET_W-1:0] ticket_counter;
  logic [tqc_pkg::TICKET_W-1:0] first_ticket_reg;

  request_t request_q[$];
  reply_t   due_replies[$];

  bit   in_taken    = 1'b0;
  bit   idle_on     = 1'b1;
  bit   pressure_go = 1'b0;
  logic long_stall  = 1'b0;
  int   in_gap      = 0;
  int   out_gap     = 0;
  int   errors      = 0;

  ticket_queue_with_cancel_unit uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_opcode         (in_opcode),
    .in_ticket_key     (in_ticket_key),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_ok            (out_ok),
    .out_position      (out_position),
    .out_issued_ticket (out_issued_ticket),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_first_ticket  (cfg_first_ticket)
  );

  always #5 clk = ~clk;

  function automatic reply_t step_ticket_queue(tqc_pkg::op_t op,
                                               logic [tqc_pkg::TICKET_W-1:0] key);
    reply_t                       r;
    int                           hit;
    int                           empty;
    int                           drop_at;
    int                           i;
    logic [tqc_pkg::TICKET_W-1:0] t;
    r       = '0;
    hit     = -1;
    empty   = -1;
    drop_at = -1;
    for (i = 0; i < tqc_pkg::DEPTH; i++) begin
      if (hit < 0 && key != '0 && ticket_slots[i] == key) hit = i;
      if (empty < 0 && ticket_slots[i] == '0) empty = i;
    end
    case (op)
      tqc_pkg::OP_TAKE: begin
        if (empty >= 0) begin
          t = (ticket_counter == '0) ? tqc_pkg::TICKET_ONE : ticket_counter;
          ticket_slots[empty] = t;
          r.ok     = 1'b1;
          r.issued = t;
          ticket_counter = (t == tqc_pkg::TICKET_MAX) ? tqc_pkg::TICKET_ONE : t + 1'b1;
        end
      end
      tqc_pkg::OP_SERVE: begin
        if (ticket_slots[0] != '0) drop_at = 0;
      end
      tqc_pkg::OP_CANCEL: begin
        drop_at = hit;
      end
      tqc_pkg::OP_CHECK: begin
        if (hit >= 0) begin
          r.ok       = 1'b1;
          r.position = (hit + 1 > tqc_pkg::POS_MAX) ?
                       tqc_pkg::POS_W'(tqc_pkg::POS_MAX) : tqc_pkg::POS_W'(hit + 1);
        end
      end
      default: begin
        r.ok = 1'b0;
      end
    endcase
    if (drop_at >= 0) begin
      r.ok = 1'b1;
      for (i = drop_at; i < tqc_pkg::DEPTH - 1; i++) ticket_slots[i] = ticket_slots[i + 1];
      ticket_slots[tqc_pkg::DEPTH - 1] = '0;
    end
    return r;
  endfunction

  function automatic request_t random_request(int take_pct);
    request_t r;
    int       used;
    int       i;
    used = 0;
    for (i = 0; i < tqc_pkg::DEPTH; i++) if (ticket_slots[i] != '0) used++;
    if ($urandom_range(0, 99) < take_pct) begin
      r.op = tqc_pkg::OP_TAKE;
    end else begin
      r.op = tqc_pkg::op_t'(2'($urandom_range(1, 3)));
    end
    r.key = tqc_pkg::TICKET_W'($urandom_range(0, 65535));
    if (used > 0 && $urandom_range(0, 9) < 8) begin
      r.key = ticket_slots[$urandom_range(0, used - 1)];
    end else if ($urandom_range(0, 4) == 0) begin
      r.key = ticket_counter;
    end
    return r;
  endfunction

  task automatic offer(tqc_pkg::op_t op, logic [tqc_pkg::TICKET_W-1:0] key);
    request_q.push_back('{op, key});
  endtask

  task automatic wait_idle();
    do @(posedge clk);
    while (in_valid || request_q.size() != 0 || due_replies.size() != 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_first_ticket(logic [tqc_pkg::TICKET_W-1:0] value);
    @(negedge clk);
    cfg_first_ticket <= value;
    cfg_valid        <= 1'b1;
    do @(posedge clk);
    while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Score requests, config writes and results on the rising edge.
  always @(posedge clk) begin : monitor
    reply_t got;
    reply_t want;
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid && !in_stall;
      if (cfg_valid && cfg_ready) begin
        first_ticket_reg = (cfg_first_ticket == '0) ? tqc_pkg::TICKET_ONE : cfg_first_ticket;
        ticket_counter   = first_ticket_reg;
      end
      if (in_taken) begin
        due_replies.push_back(step_ticket_queue(tqc_pkg::op_t'(in_opcode), in_ticket_key));
      end
      if (out_valid && !out_stall) begin
        got = {out_ok, out_position, out_issued_ticket};
        if (due_replies.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %h", $time, got);
          errors++;
        end else begin
          want = due_replies.pop_front();
          if (got.ok !== want.ok) begin
            $display("%0t: ok mismatch, expected %0d, got %0d", $time, want.ok, got.ok);
            errors++;
          end
          if (got.position !== want.position) begin
            $display("%0t: position mismatch, expected %0d, got %0d",
                     $time, want.position, got.position);
            errors++;
          end
          if (got.issued !== want.issued) begin
            $display("%0t: issued_ticket mismatch, expected %0d, got %0d",
                     $time, want.issued, got.issued);
            errors++;
          end
        end
      end
    end
  end

  // Present the next request once the current one is accepted.
  always @(negedge clk) begin : driver
    request_t nxt;
    if (rst_n && (!in_valid || in_taken)) begin
      if (in_gap > 0) begin
        in_gap--;
        in_valid <= 1'b0;
      end else if (request_q.size() > 0) begin
        nxt = request_q.pop_front();
        in_valid      <= 1'b1;
        in_opcode     <= nxt.op;
        in_ticket_key <= nxt.key;
        if (idle_on && $urandom_range(0, 9) == 0) in_gap = $urandom_range(1, 18);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin : receiver
    logic hold;
    hold = 1'b0;
    if (out_gap > 0) begin
      out_gap--;
      hold = 1'b1;
    end else if (idle_on && $urandom_range(0, 9) == 0) begin
      out_gap = $urandom_range(0, 17);
      hold    = 1'b1;
    end
    out_stall <= hold | long_stall;
  end

  // Hold the result side off long enough to back up the input.
  initial begin : long_hold
    wait (pressure_go);
    @(negedge clk);
    long_stall <= 1'b1;
    repeat (80) @(negedge clk);
    long_stall <= 1'b0;
  end

  initial begin : watchdog
    #5_000_000;
    $display("tb_ticket_queue_with_cancel_unit NOT OK");
    $finish;
  end

  initial begin : main
    logic [tqc_pkg::TICKET_W-1:0] phase_first [5];
    int                           ph;
    int                           n;
    int                           take_pct;
    foreach (ticket_slots[i]) ticket_slots[i] = '0;
    first_ticket_reg = tqc_pkg::TICKET_ONE;
    ticket_counter   = tqc_pkg::TICKET_ONE;
    phase_first[0] = tqc_pkg::TICKET_MAX;
    phase_first[1] = '0;
    phase_first[2] = tqc_pkg::TICKET_W'($urandom_range(1, 65535));
    phase_first[3] = 16'hFFF0;
    phase_first[4] = tqc_pkg::TICKET_ONE;
    repeat (10) @(negedge clk);
    rst_n <= 1'b1;

    // empty queue, fill to full, then lookups and removals
    offer(tqc_pkg::OP_SERVE, 16'd1);
    offer(tqc_pkg::OP_CHECK, 16'd1);
    repeat (8) offer(tqc_pkg::OP_TAKE, 16'd0);
    offer(tqc_pkg::OP_TAKE, tqc_pkg::TICKET_MAX);
    offer(tqc_pkg::OP_CHECK, 16'd1);
    offer(tqc_pkg::OP_CHECK, 16'd8);
    offer(tqc_pkg::OP_CHECK, 16'd0);
    offer(tqc_pkg::OP_CANCEL, 16'd0);
    offer(tqc_pkg::OP_CANCEL, 16'd4);
    offer(tqc_pkg::OP_SERVE, 16'd0);
    wait_idle();

    // duplicate ticket: lookups act on the one nearest the head
    write_first_ticket(16'd6);
    offer(tqc_pkg::OP_TAKE, 16'd0);
    offer(tqc_pkg::OP_CHECK, 16'd6);
    offer(tqc_pkg::OP_CANCEL, 16'd6);
    offer(tqc_pkg::OP_CHECK, 16'd6);
    wait_idle();

    // counter wrap at the top of the ticket range
    write_first_ticket(tqc_pkg::TICKET_MAX);
    offer(tqc_pkg::OP_TAKE, 16'd0);
    offer(tqc_pkg::OP_TAKE, 16'd0);
    offer(tqc_pkg::OP_TAKE, 16'd0);
    offer(tqc_pkg::OP_CHECK, tqc_pkg::TICKET_MAX);

    for (ph = 0; ph < 5; ph++) begin
      wait_idle();
      write_first_ticket(phase_first[ph]);
      idle_on = (ph != 4);
      if (ph == 2) pressure_go = 1'b1;
      take_pct = (ph % 2 == 0) ? 55 : 30;
      for (n = 0; n < 130; n++) begin
        while (request_q.size() >= 4) @(negedge clk);
        request_q.push_back(random_request(take_pct));
      end
    end
    wait_idle();

    if (errors == 0) begin
      $display("tb_ticket_queue_with_cancel_unit OK");
    end else begin
      $display("tb_ticket_queue_with_cancel_unit NOT OK");
    end
    $finish;
  end

endmodule

>>> sim.f
src/tqc_pkg.sv
src/tqc_cell.sv
src/tqc_chain.sv
src/ticket_queue_with_cancel_unit.sv
src/tqc_checker.sv
tb/tb_ticket_queue_with_cancel_unit.sv
